// ===== rtl/lfrb_pkg.sv =====
// Shared types, constants and pointer helpers for the length-prefixed frame ring buffer.
// No dependencies; the controller, core and checker refer to it by scoped names.
package lfrb_pkg;

	// Ring store geometry
	localparam int STORE_DEPTH = 65536;
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W       = 16;
	localparam int CMP_W       = LEN_W + 1;

	localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W+1)'(STORE_DEPTH);
	localparam logic [PTR_W-1:0] FULL_HELD = PTR_W'(STORE_DEPTH - 1);
	localparam logic [CMP_W-1:0] MAX_LEN   = CMP_W'(STORE_DEPTH - 1);

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd65533;

	typedef logic [PTR_W-1:0] ptr_t;

	// Result codes
	typedef enum logic [2:0] {
		ST_PAYLOAD  = 3'd0,
		ST_PUSHED   = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOFRAME  = 3'd3,
		ST_BADLEN   = 3'd4,
		ST_TOOLARGE = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	// Item function codes
	localparam logic FN_PUSH = 1'b0;
	localparam logic FN_PULL = 1'b1;

	// Store access request from the controller to the RAM
	typedef struct packed {
		logic       we;
		ptr_t       waddr;
		logic [7:0] wdata;
		ptr_t       raddr;
	} mem_req_t;

	// Advance a ring pointer by a small step, wrapping at the store depth
	function automatic ptr_t ptr_add(input ptr_t p, input logic [1:0] step);
		logic [PTR_W:0] s;
		s = {1'b0, p} + (PTR_W+1)'(step);
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[PTR_W-1:0];
	endfunction

	// Bytes held between read and write pointers
	function automatic ptr_t held_count(input ptr_t wp, input ptr_t rp);
		logic [PTR_W:0] d;
		d = {1'b0, wp} - {1'b0, rp};
		if (d[PTR_W]) begin
			d = d + DEPTH_X;
		end
		return d[PTR_W-1:0];
	endfunction

endpackage

// ===== rtl/lfrb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lfrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lfrb_ctrl.sv =====
// Deframing controller: pointers, frame state, header check and result register.
// Depends on lfrb_pkg; drives the byte store through a lfrb_pkg::mem_req_t request.
module lfrb_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [7:0]              in_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic [7:0]              data_byte,
	output logic                    last_byte,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [15:0]             cfg_data,
	output lfrb_pkg::mem_req_t      mem_req,
	input  logic [7:0]              mem_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_HDR_HI,
		S_HDR_LO,
		S_PAY
	} state_t;

	state_t                           state_q;
	lfrb_pkg::ptr_t                   rp_q;
	lfrb_pkg::ptr_t                   wp_q;
	logic [lfrb_pkg::LEN_W-1:0]       rem_q;
	logic                             inside_q;
	logic [7:0]                       hi_q;
	logic [lfrb_pkg::LEN_W-1:0]       max_payload_q;
	logic                             out_valid_q;
	lfrb_pkg::status_t                status_q;
	logic [7:0]                       data_q;
	logic                             last_q;

	logic                             accept;
	lfrb_pkg::ptr_t                   held;
	logic                             full;
	logic [lfrb_pkg::LEN_W-1:0]       len;
	logic                             len_bad;
	logic                             len_short;
	logic                             too_large;
	logic                             frame_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_byte = data_q;
	assign last_byte = last_q;

	// Occupancy and header checks
	assign held      = lfrb_pkg::held_count(wp_q, rp_q);
	assign full      = (held == lfrb_pkg::FULL_HELD);
	assign len       = {hi_q, mem_rdata};
	assign len_bad   = (len < 16'd2) || ({1'b0, len} > lfrb_pkg::MAX_LEN);
	assign len_short = ({1'b0, held} < {1'b0, len});
	assign too_large = ((len - 16'd2) > max_payload_q);
	assign frame_go  = !len_bad && !len_short && !too_large && (len != 16'd2);

	// Store access: one write for a push that finds room, one read per header or payload word
	always_comb begin
		mem_req.we    = accept && (func == lfrb_pkg::FN_PUSH) && !full;
		mem_req.waddr = wp_q;
		mem_req.wdata = in_byte;
		case (state_q)
			S_HDR_HI: mem_req.raddr = lfrb_pkg::ptr_add(rp_q, 2'd1);
			S_HDR_LO: mem_req.raddr = lfrb_pkg::ptr_add(rp_q, 2'd2);
			default:  mem_req.raddr = rp_q;
		endcase
	end

	// State, pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rp_q          <= '0;
			wp_q          <= '0;
			rem_q         <= '0;
			inside_q      <= 1'b0;
			max_payload_q <= lfrb_pkg::MAX_PAYLOAD_RST;
			out_valid_q   <= 1'b0;
			status_q      <= lfrb_pkg::ST_PAYLOAD;
			data_q        <= '0;
			last_q        <= 1'b0;
			hi_q          <= '0;
		end else begin
			if (cfg_valid) begin
				max_payload_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == lfrb_pkg::FN_PUSH) begin
							out_valid_q <= 1'b1;
							data_q      <= '0;
							last_q      <= 1'b0;
							if (full) begin
								status_q <= lfrb_pkg::ST_FULL;
							end else begin
								status_q <= lfrb_pkg::ST_PUSHED;
								wp_q     <= lfrb_pkg::ptr_add(wp_q, 2'd1);
							end
						end else if (inside_q) begin
							state_q <= S_PAY;
						end else if (held < lfrb_pkg::ptr_t'(2)) begin
							out_valid_q <= 1'b1;
							status_q    <= lfrb_pkg::ST_NOFRAME;
							data_q      <= '0;
							last_q      <= 1'b0;
						end else begin
							state_q <= S_HDR_HI;
						end
					end
				end

				// High length word arrives; low word read is under way
				S_HDR_HI: begin
					hi_q    <= mem_rdata;
					state_q <= S_HDR_LO;
				end

				// Full length known: decide
				S_HDR_LO: begin
					data_q <= '0;
					last_q <= 1'b0;
					if (frame_go) begin
						rp_q     <= lfrb_pkg::ptr_add(rp_q, 2'd2);
						rem_q    <= len - 16'd2;
						inside_q <= 1'b1;
						state_q  <= S_PAY;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (len_bad) begin
							status_q <= lfrb_pkg::ST_BADLEN;
							rp_q     <= '0;
							wp_q     <= '0;
						end else if (len_short) begin
							status_q <= lfrb_pkg::ST_NOFRAME;
						end else if (too_large) begin
							status_q <= lfrb_pkg::ST_TOOLARGE;
							rp_q     <= '0;
							wp_q     <= '0;
						end else begin
							status_q <= lfrb_pkg::ST_EMPTY;
							last_q   <= 1'b1;
							rp_q     <= lfrb_pkg::ptr_add(rp_q, 2'd2);
						end
					end
				end

				// Payload word arrives from the store
				S_PAY: begin
					out_valid_q <= 1'b1;
					status_q    <= lfrb_pkg::ST_PAYLOAD;
					data_q      <= mem_rdata;
					last_q      <= (rem_q == 16'd1);
					inside_q    <= (rem_q != 16'd1);
					rem_q       <= rem_q - 16'd1;
					rp_q        <= lfrb_pkg::ptr_add(rp_q, 2'd1);
					state_q     <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/length_prefixed_frame_ring_buffer_core.sv =====
// A push, or a pull with fewer than two bytes held, gives its result from S_IDLE; a pull in a
// frame passes S_PAY (one store read); a pull at a frame start passes S_HDR_HI, S_HDR_LO for
// a bad length or incomplete, oversized or empty frame, then S_PAY for the first payload word.
// Throughput: one item at a time; the next word is taken as the previous result is taken.
// Reset (arst_n low, asynchronous): pointers, frame state and result register clear,
// max_payload returns to 65533; the byte store itself is not cleared.
module length_prefixed_frame_ring_buffer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  data_byte,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	lfrb_pkg::mem_req_t mem_req;
	logic [7:0]         mem_rdata;

	lfrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Byte ring store
	lfrb_ram #(
		.WIDTH (8),
		.DEPTH (lfrb_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== rtl/lfrb_checker.sv =====
// Port-level checks for the frame ring buffer core, attached by bind.
// Depends on lfrb_pkg for result codes.
module lfrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  data_byte,
	input logic        last_byte
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_byte)
			&& $stable(last_byte))
		else $error("result word changed while stalled");

	// Only payload words carry data
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != lfrb_pkg::ST_PAYLOAD) |-> (data_byte == 8'd0))
		else $error("nonzero data on a non-payload result");

	// Status-only results other than an empty frame never flag an end of frame
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == lfrb_pkg::ST_PUSHED || status == lfrb_pkg::ST_FULL
			|| status == lfrb_pkg::ST_NOFRAME || status == lfrb_pkg::ST_BADLEN
			|| status == lfrb_pkg::ST_TOOLARGE) |-> !last_byte)
		else $error("last flag on a status-only result");

	// An empty frame always closes the frame
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == lfrb_pkg::ST_EMPTY) |-> last_byte)
		else $error("empty frame without last flag");

endmodule

bind length_prefixed_frame_ring_buffer_core lfrb_checker u_lfrb_checker (.*);
